// ===== rtl/emgd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package emgd_pkg;

    // Ring buffer geometry (depth is a power of two, wrap by truncation)
    localparam int BUF_DEPTH = 256;
    localparam int PTR_W     = $clog2(BUF_DEPTH);
    localparam int FILL_W    = PTR_W + 1;

    // Frame format
    localparam logic [7:0] START_BYTE  = 8'hA5;
    localparam logic [7:0] END_BYTE    = 8'h5A;
    localparam logic [7:0] MAX_LEN     = 8'd128;
    localparam logic [7:0] MIN_FRAME   = 8'd7;
    localparam logic [7:0] DATA_OFFSET = 8'd12;
    localparam logic [7:0] HDR_BYTES   = 8'd10;
    localparam logic [7:0] TRAIL_BYTES = 8'd3;

    // Results per received byte
    localparam int MAX_RESULTS = 59;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Configuration registers
    localparam logic [7:0] WANTED_TYPE_RESET = 8'd18;
    localparam logic       REG_WANTED_TYPE   = 1'b0;

    // Ring memory access bundle
    typedef struct packed {
        logic             wr_en;
        logic [PTR_W-1:0] wr_addr;
        logic [7:0]       wr_data;
        logic [PTR_W-1:0] rd_addr;
    } ring_req_t;

endpackage

`default_nettype wire

// ===== rtl/emgd_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none

module emgd_ring (
    input  wire logic               aclk,
    input  wire emgd_pkg::ring_req_t req,
    output logic [7:0]              rd_data
);
    import emgd_pkg::*;

    logic [7:0] mem [BUF_DEPTH];
    logic [7:0] rd_data_reg;

    // Single write port, registered read port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/emgd_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module emgd_cfg (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [7:0]       wanted_type
);
    import emgd_pkg::*;

    logic [7:0] wanted_type_reg;
    logic [7:0] wanted_type_next;
    logic       wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_WANTED_TYPE);

    // Register write
    always_comb begin
        wanted_type_next = wanted_type_reg;
        if (wr_hit) begin
            wanted_type_next = pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wanted_type_reg <= WANTED_TYPE_RESET;
        end else begin
            wanted_type_reg <= wanted_type_next;
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[2])
            REG_WANTED_TYPE: prdata = {24'd0, wanted_type_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign wanted_type = wanted_type_reg;

endmodule

`default_nettype wire

// ===== rtl/emgd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module emgd_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [7:0]          wanted_type,
    // byte input
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,
    // sample output
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic signed [15:0]       m_tdata,
    output logic                     m_tlast,
    // ring memory
    output emgd_pkg::ring_req_t      ring_req,
    input  wire logic [7:0]          ring_rd_data
);
    import emgd_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_HEAD = 8'b0000_0010,
        S_CHK0 = 8'b0000_0100,
        S_CHK1 = 8'b0000_1000,
        S_CHK2 = 8'b0001_0000,
        S_CHK3 = 8'b0010_0000,
        S_RDHI = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [PTR_W-1:0]    sp_reg, sp_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [7:0]          len_reg, len_next;
    logic [7:0]          lo_reg, lo_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    nsmp_reg, nsmp_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [15:0]         out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;

    logic                accept;
    logic                out_free;
    logic [FILL_W-1:0]   frame_len;
    logic [FILL_W-1:0]   fill_less1;
    logic [FILL_W-1:0]   fill_less_frame;
    logic [7:0]          len_minus_hdr;
    logic [CNT_W-1:0]    nsmp_calc;
    logic [CNT_W:0]      cnt_sum;
    logic [7:0]          lo_off;
    logic [7:0]          hi_off;
    logic [7:0]          next_lo_off;
    logic                last_smp;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    // Frame arithmetic
    assign frame_len       = FILL_W'(len_reg) + FILL_W'(TRAIL_BYTES);
    assign fill_less1      = fill_reg - FILL_W'(1);
    assign fill_less_frame = fill_reg - frame_len;
    assign len_minus_hdr   = len_reg - HDR_BYTES;
    assign nsmp_calc       = (len_reg >= HDR_BYTES) ? CNT_W'(len_minus_hdr >> 1) : '0;
    assign cnt_sum         = {1'b0, cnt_reg} + {1'b0, nsmp_calc};
    assign lo_off          = DATA_OFFSET + {1'b0, idx_reg, 1'b0};
    assign hi_off          = lo_off + 8'd1;
    assign next_lo_off     = lo_off + 8'd2;
    assign last_smp        = (idx_reg + CNT_W'(1)) == nsmp_reg;

    // Sequencer: append byte, then scan the buffer through the memory
    always_comb begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        lo_next        = lo_reg;
        cnt_next       = cnt_reg;
        nsmp_next      = nsmp_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        ring_req.wr_en   = 1'b0;
        ring_req.wr_addr = sp_reg + fill_reg[PTR_W-1:0];
        ring_req.wr_data = s_tdata;
        ring_req.rd_addr = sp_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    // full buffer: oldest byte goes, new byte lands in its slot
                    ring_req.wr_en = 1'b1;
                    if (fill_reg[PTR_W]) begin
                        sp_next = sp_reg + PTR_W'(1);
                    end else begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    cnt_next   = '0;
                    state_next = S_HEAD;
                end
            end
            S_HEAD: begin
                state_next = S_CHK0;
            end
            S_CHK0: begin
                if (ring_rd_data != START_BYTE) begin
                    sp_next    = sp_reg + PTR_W'(1);
                    fill_next  = fill_less1;
                    state_next = (fill_less1 == '0) ? S_IDLE : S_HEAD;
                end else if (fill_reg < FILL_W'(MIN_FRAME)) begin
                    state_next = S_IDLE;
                end else begin
                    ring_req.rd_addr = sp_reg + PTR_W'(1);
                    state_next       = S_CHK1;
                end
            end
            S_CHK1: begin
                len_next         = ring_rd_data;
                ring_req.rd_addr = sp_reg + PTR_W'(2);
                state_next       = S_CHK2;
            end
            S_CHK2: begin
                if (ring_rd_data != wanted_type || len_reg > MAX_LEN) begin
                    sp_next    = sp_reg + PTR_W'(1);
                    fill_next  = fill_less1;
                    state_next = (fill_less1 == '0) ? S_IDLE : S_HEAD;
                end else if (fill_reg < frame_len) begin
                    // incomplete frame waits for more bytes
                    state_next = S_IDLE;
                end else begin
                    ring_req.rd_addr = sp_reg + PTR_W'(len_reg + 8'd2);
                    state_next       = S_CHK3;
                end
            end
            S_CHK3: begin
                if (ring_rd_data != END_BYTE) begin
                    sp_next    = sp_reg + PTR_W'(1);
                    fill_next  = fill_less1;
                    state_next = (fill_less1 == '0) ? S_IDLE : S_HEAD;
                end else if (cnt_sum > (CNT_W + 1)'(MAX_RESULTS)) begin
                    // no room left in this transaction's results
                    state_next = S_IDLE;
                end else if (nsmp_calc == '0) begin
                    sp_next    = sp_reg + PTR_W'(frame_len);
                    fill_next  = fill_less_frame;
                    state_next = (fill_less_frame == '0) ? S_IDLE : S_HEAD;
                end else begin
                    nsmp_next        = nsmp_calc;
                    idx_next         = '0;
                    ring_req.rd_addr = sp_reg + PTR_W'(DATA_OFFSET);
                    state_next       = S_RDHI;
                end
            end
            S_RDHI: begin
                lo_next          = ring_rd_data;
                ring_req.rd_addr = sp_reg + PTR_W'(hi_off);
                state_next       = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {ring_rd_data, lo_reg};
                    out_last_next  = last_smp;
                    cnt_next       = cnt_reg + CNT_W'(1);
                    if (last_smp) begin
                        sp_next    = sp_reg + PTR_W'(frame_len);
                        fill_next  = fill_less_frame;
                        state_next = (fill_less_frame == '0) ? S_IDLE : S_HEAD;
                    end else begin
                        idx_next         = idx_reg + CNT_W'(1);
                        ring_req.rd_addr = sp_reg + PTR_W'(next_lo_off);
                        state_next       = S_RDHI;
                    end
                end else begin
                    // hold the high byte on the read port while stalled
                    ring_req.rd_addr = sp_reg + PTR_W'(hi_off);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        len_reg      <= len_next;
        lo_reg       <= lo_next;
        nsmp_reg     <= nsmp_next;
        idx_reg      <= idx_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/emg_frame_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A new byte is taken only in the idle state; after each byte the buffer is rescanned
// through the single read port of the ring, each sample needing a low and a high byte read,
// and s_tready stays low until the scan returns to idle.
// Reset (aresetn low, synchronous): buffer emptied, output invalid, wanted_type = 18.
module emg_frame_deframer (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // received bytes; s_tdata: [7:0] rx_byte
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,
    // samples; m_tdata: [15:0] sample, m_tlast: last sample of frame
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic signed [15:0]      m_tdata,
    output logic                    m_tlast,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import emgd_pkg::*;

    ring_req_t  ring_req;
    logic [7:0] ring_rd_data;
    logic [7:0] wanted_type;

    emgd_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .wanted_type (wanted_type)
    );

    emgd_ring u_ring (
        .aclk    (aclk),
        .req     (ring_req),
        .rd_data (ring_rd_data)
    );

    emgd_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wanted_type  (wanted_type),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .ring_req     (ring_req),
        .ring_rd_data (ring_rd_data)
    );

endmodule

`default_nettype wire

// ===== dv/emg_frame_deframer_test.sv =====
`timescale 1ns / 1ps

module emg_frame_deframer_test;
    import emgd_pkg::*;

    localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
    localparam int unsigned DRAIN_CYCLES   = 1000;
    localparam int unsigned PHASE_BYTES    = 20;
    localparam logic [2:0]  TYPE_ADDR      = 3'(4 * REG_WANTED_TYPE);

    typedef struct packed {
        logic signed [15:0] value;
        logic               last;
    } sample_t;

    // Frame finder mirror plus queue of samples still owed by the block
    class sample_ledger;
        logic [7:0]  ring [BUF_DEPTH];
        int unsigned head;
        int unsigned fill;
        logic [7:0]  wanted;
        sample_t     due_q[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned frames;
        int unsigned rejects;

        function new();
            head       = 0;
            fill       = 0;
            wanted     = WANTED_TYPE_RESET;
            mismatches = 0;
            checked    = 0;
            frames     = 0;
            rejects    = 0;
        endfunction

        function logic [7:0] at(int unsigned off);
            return ring[(head + off) % BUF_DEPTH];
        endfunction

        function void drop(int unsigned n);
            if (n > fill)
                n = fill;
            head = (head + n) % BUF_DEPTH;
            fill -= n;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s", $realtime, msg);
        endfunction

        // Append one received byte and decode complete frames, up to MAX_RESULTS samples per byte
        function void take_byte(logic [7:0] b);
            int unsigned len;
            int unsigned span;
            int unsigned n;
            int unsigned emitted;
            sample_t     s;
            emitted = 0;
            if (fill >= BUF_DEPTH)
                drop(1);
            ring[(head + fill) % BUF_DEPTH] = b;
            fill++;
            while (fill >= 1) begin
                if (at(0) != START_BYTE) begin
                    drop(1);
                    continue;
                end
                if (fill < MIN_FRAME)
                    break;
                len = at(1);
                if (at(2) != wanted || len > MAX_LEN) begin
                    rejects++;
                    drop(1);
                    continue;
                end
                span = len + TRAIL_BYTES;
                // incomplete frame: hold until the rest arrives
                if (fill < span)
                    break;
                if (at(len + 2) != END_BYTE) begin
                    rejects++;
                    drop(1);
                    continue;
                end
                n = (len >= HDR_BYTES) ? (len - HDR_BYTES) / 2 : 0;
                if (n > MAX_RESULTS)
                    n = MAX_RESULTS;
                if (emitted + n > MAX_RESULTS)
                    break;
                for (int unsigned i = 0; i < n; i++) begin
                    s.value = {at(DATA_OFFSET + 2 * i + 1), at(DATA_OFFSET + 2 * i)};
                    s.last  = (i + 1 == n);
                    due_q.insert(due_q.size(), s);
                    emitted++;
                end
                frames++;
                drop(span);
            end
        endfunction

        function void match_sample(logic signed [15:0] got, logic got_last);
            sample_t want;
            if (due_q.size() == 0) begin
                flag($sformatf("unexpected sample %0d last %0b", got, got_last));
            end else begin
                want = due_q.pop_front();
                checked++;
                if (want.value !== got || want.last !== got_last)
                    flag($sformatf("sample mismatch: expected %0d last %0b, got %0d last %0b",
                                   want.value, want.last, got, got_last));
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;     // [7:0] rx_byte
    logic               m_tvalid;
    logic               m_tready;
    logic signed [15:0] m_tdata;     // [15:0] sample
    logic               m_tlast;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    sample_ledger ledger;
    logic [7:0]   cur_type;
    int unsigned  bytes_sent;
    bit           quiet;

    emg_frame_deframer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < TIMEOUT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("end of test: mismatches");
        $finish;
    end

    // Sample sink: random short stalls, one long hold-off mid-run
    initial begin
        int unsigned stall_left;
        int unsigned hold_left;
        bit          held;
        stall_left = 0;
        hold_left  = 0;
        held       = 1'b0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && bytes_sent >= 100) begin
                held      = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_tready   = 1'b0;
                stall_left = $urandom_range(1, 3) - 1;
            end else begin
                m_tready = 1'b1;
            end
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                ledger.match_sample(m_tdata, m_tlast);
        end
    end

    // Called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do
            @(posedge aclk);
        while (!s_tready);
        ledger.take_byte(b);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // First keep bytes of a frame; end byte overrides the type byte when len is 0
    task automatic send_frame(input int unsigned len, input logic [7:0] kind,
                              input bit good_end, input int unsigned keep);
        logic [7:0] b;
        for (int unsigned j = 0; j < keep; j++) begin
            b = 8'($urandom);
            if (j == 0) begin
                b = START_BYTE;
            end else if (j == len + 2) begin
                if (good_end)
                    b = END_BYTE;
                else if (b == END_BYTE)
                    b = ~b;
            end else if (j == 1) begin
                b = 8'(len);
            end else if (j == 2) begin
                b = kind;
            end
            send_byte(b);
        end
    endtask

    // Write wanted_type, then read it back
    task automatic set_type(input logic [7:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = TYPE_ADDR;
        pwdata  = {24'd0, val};
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        if (pready) begin
            ledger.wanted = val;
            cur_type      = val;
        end
        @(negedge aclk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        if (prdata !== {24'd0, val})
            ledger.flag($sformatf("wanted_type readback: expected %0h, got %0h",
                                  val, prdata));
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic wait_drained();
        while (ledger.due_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Mostly good frames; the rest wrong type, bad end, oversize length,
    // noise and truncated frames that force rescans
    task automatic run_traffic(input int unsigned budget);
        int unsigned start;
        int unsigned pick;
        int unsigned r;
        int unsigned len;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            pick = $urandom_range(0, 99);
            r    = $urandom_range(0, 9);
            if (r < 8)
                len = $urandom_range(10, 36);
            else if (r == 8)
                len = $urandom_range(0, 9);
            else
                len = $urandom_range(37, MAX_LEN);
            if (pick < 55)
                send_frame(len, cur_type, 1'b1, len + 3);
            else if (pick < 65)
                send_frame(len, cur_type ^ 8'($urandom_range(1, 255)), 1'b1, len + 3);
            else if (pick < 73)
                send_frame(len, cur_type, 1'b0, len + 3);
            else if (pick < 78)
                send_frame($urandom_range(MAX_LEN + 1, 255), cur_type, 1'b1,
                           $urandom_range(3, 10));
            else if (pick < 88)
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            else
                send_frame(len, cur_type, 1'b1, $urandom_range(1, len + 2));
        end
    endtask

    initial begin
        logic [7:0] type_plan [5];
        ledger     = new();
        cur_type   = WANTED_TYPE_RESET;
        bytes_sent = 0;
        quiet      = 1'b0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'd0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = 3'd0;
        pwdata     = 32'd0;
        type_plan  = '{8'h00, 8'hFF, END_BYTE, START_BYTE, 8'($urandom)};
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: noise extremes, a frame with both sample extremes,
        // then a short-length frame that is held until 7 bytes are in
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(START_BYTE);
        send_byte(8'd14);
        send_byte(cur_type);
        repeat (9) send_byte(8'($urandom));
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(END_BYTE);
        send_byte(START_BYTE);
        send_byte(8'd2);
        send_byte(cur_type);
        send_byte(8'h33);
        send_byte(END_BYTE);
        send_byte(8'h01);
        send_byte(8'h02);
        run_traffic(PHASE_BYTES);

        // One phase per type setting; the final phase returns to reset type, no idling
        for (int p = 0; p < 6; p++) begin
            s_tvalid = 1'b0;
            wait_drained();
            if (p < 5) begin
                set_type(type_plan[p]);
            end else begin
                set_type(WANTED_TYPE_RESET);
                quiet = 1'b1;
            end
            if (p == 1)
                send_frame(MAX_LEN, cur_type, 1'b1, MAX_LEN + 3);
            run_traffic(PHASE_BYTES);
        end
        s_tvalid = 1'b0;
        wait_drained();

        if (ledger.due_q.size() != 0)
            ledger.flag($sformatf("%0d samples never arrived", ledger.due_q.size()));
        $display("covered %0d bytes over 7 type settings: %0d frames decoded, %0d rejected",
                 bytes_sent, ledger.frames, ledger.rejects);
        $display("%0d samples checked, %0d mismatches", ledger.checked, ledger.mismatches);
        if (ledger.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/emgd_pkg.sv
rtl/emgd_ring.sv
rtl/emgd_cfg.sv
rtl/emgd_ctrl.sv
rtl/emg_frame_deframer.sv
dv/emg_frame_deframer_test.sv
